### design/hsfs_pkg.sv
// Shared types and constants for the scaled HMM forward step.
package hsfs_pkg;

	localparam int MAX_STATES_DEF  = 16;
	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int RESULT_LIMIT    = 16;

	localparam int PROB_FRAC_BITS = 16;
	localparam int PROB_W         = PROB_FRAC_BITS + 1;
	localparam int CFG_W          = 5;
	localparam int IDX_W          = 4;
	localparam int COL_W          = 8;
	localparam int SYM_W          = 8;
	localparam int SCALE_W        = 32;

	// accumulator: sum of up to 16 products of two Q1.F values
	localparam int ACC_W   = 2 * PROB_FRAC_BITS + 1 + 4;
	localparam int FACT_W  = ACC_W - PROB_FRAC_BITS + 1;
	localparam int U_W     = FACT_W + PROB_W;
	localparam int TOT_W   = U_W + 4;

	localparam int SCALE_STEPS = 16 + 2 * PROB_FRAC_BITS;
	localparam int CNT_W       = $clog2(SCALE_STEPS);

	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
	localparam logic [ACC_W:0]    ACC_HALF = (ACC_W + 1)'(1) << (PROB_FRAC_BITS - 1);
	localparam logic [TOT_W-1:0]  SMALL_LIM = TOT_W'(1) << (2 * PROB_FRAC_BITS - 16);

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_TRANS = 2'd1,
		MODE_EMIS  = 2'd2,
		MODE_OBS   = 2'd3
	} mode_t;

	typedef struct packed {
		logic             tbl_write;
		logic             begin_item;
		logic             mac_issue;
		logic             fetch;
		logic             fact;
		logic             umul;
		logic             uacc;
		logic             ds_load;
		logic             da_load;
		logic             div_step;
		logic             scale_save;
		logic             emit;
		logic             start;
		logic             last;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

### design/hsfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsfs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### design/hsfs_ctrl.sv
// Sequencer for table loads, forward accumulation, scaling and result output.
module hsfs_ctrl #(
	parameter int MAX_STATES = hsfs_pkg::MAX_STATES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic                       seq_start,
	input  logic                       cfg_we,
	input  logic [hsfs_pkg::CFG_W-1:0] cfg_data,
	output hsfs_pkg::cmd_t             cmd,
	input  hsfs_pkg::sts_t             sts
);

	localparam int NS = (MAX_STATES < hsfs_pkg::RESULT_LIMIT) ? MAX_STATES
		: hsfs_pkg::RESULT_LIMIT;
	localparam logic [hsfs_pkg::CFG_W-1:0] NS_N = hsfs_pkg::CFG_W'(NS);

	typedef enum logic [3:0] {
		S_IDLE, S_MAC, S_MAC_END, S_FETCH, S_FACT, S_UMUL, S_UACC,
		S_DS_LD, S_DS, S_DS_SAVE, S_DA_LD, S_DA, S_EMIT
	} state_t;

	state_t                       state_q;
	logic [hsfs_pkg::IDX_W-1:0]   i_q, j_q;
	logic [hsfs_pkg::CFG_W-1:0]   n_q, active_q, n_next;
	logic [hsfs_pkg::CNT_W-1:0]   cnt_q;
	logic                         start_q;
	logic                         accept, is_obs, i_last, j_last;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign is_obs   = (mode == hsfs_pkg::MODE_OBS);
	assign i_last   = (hsfs_pkg::CFG_W'(i_q) + 1'b1 == n_q);
	assign j_last   = (hsfs_pkg::CFG_W'(j_q) + 1'b1 == n_q);

	always_comb begin
		if (active_q == '0)
			n_next = hsfs_pkg::CFG_W'(1);
		else if (active_q > NS_N)
			n_next = NS_N;
		else
			n_next = active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			n_q      <= NS_N;
			cnt_q    <= '0;
			start_q  <= 1'b0;
			active_q <= hsfs_pkg::CFG_W'(hsfs_pkg::RESULT_LIMIT);
		end else begin
			if (cfg_we)
				active_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (accept && is_obs) begin
						n_q     <= n_next;
						start_q <= seq_start;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= seq_start ? S_FETCH : S_MAC;
					end
				end
				S_MAC: begin
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_MAC_END;
					end else
						i_q <= i_q + 1'b1;
				end
				S_MAC_END: state_q <= S_FACT;
				S_FETCH:   state_q <= S_FACT;
				S_FACT:    state_q <= S_UMUL;
				S_UMUL:    state_q <= S_UACC;
				S_UACC: begin
					if (j_last) begin
						j_q     <= '0;
						state_q <= S_DS_LD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= start_q ? S_FETCH : S_MAC;
					end
				end
				S_DS_LD: begin
					cnt_q   <= '0;
					state_q <= S_DS;
				end
				S_DS: begin
					if (cnt_q == hsfs_pkg::CNT_W'(hsfs_pkg::SCALE_STEPS - 1))
						state_q <= S_DS_SAVE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_DS_SAVE: state_q <= S_DA_LD;
				S_DA_LD: begin
					cnt_q   <= '0;
					state_q <= S_DA;
				end
				S_DA: begin
					if (cnt_q == hsfs_pkg::CNT_W'(hsfs_pkg::PROB_FRAC_BITS - 1))
						state_q <= S_EMIT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (j_last)
							state_q <= S_IDLE;
						else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_DA_LD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.i          = i_q;
		cmd.j          = j_q;
		cmd.start      = start_q;
		cmd.last       = j_last;
		case (state_q)
			S_IDLE: begin
				cmd.tbl_write  = accept && !is_obs;
				cmd.begin_item = accept && is_obs;
			end
			S_MAC:     cmd.mac_issue  = 1'b1;
			S_MAC_END: cmd.fetch      = 1'b1;
			S_FETCH:   cmd.fetch      = 1'b1;
			S_FACT:    cmd.fact       = 1'b1;
			S_UMUL:    cmd.umul       = 1'b1;
			S_UACC:    cmd.uacc       = 1'b1;
			S_DS_LD:   cmd.ds_load    = 1'b1;
			S_DS:      cmd.div_step   = 1'b1;
			S_DS_SAVE: cmd.scale_save = 1'b1;
			S_DA_LD:   cmd.da_load    = 1'b1;
			S_DA:      cmd.div_step   = 1'b1;
			S_EMIT:    cmd.emit       = sts.out_free;
			default:   cmd.tbl_write  = 1'b0;
		endcase
	end

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !sts.out_free) |=> (state_q == S_EMIT && $stable(j_q)))
		else $error("result dropped while output busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE))
		else $error("no return to idle after final result");

	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (hsfs_pkg::CFG_W'(j_q) < n_q))
		else $error("state counter beyond active states");

	a_obs_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && is_obs) |=> (state_q == S_MAC || state_q == S_FETCH))
		else $error("observe request not started");

endmodule

### design/hsfs_dpath.sv
// Tables, multiply-accumulate, shared divider and output register.
module hsfs_dpath #(
	parameter int MAX_STATES  = hsfs_pkg::MAX_STATES_DEF,
	parameter int NUM_SYMBOLS = hsfs_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsfs_pkg::cmd_t               cmd,
	output hsfs_pkg::sts_t               sts,
	input  logic [1:0]                   mode,
	input  logic [hsfs_pkg::IDX_W-1:0]   row_index,
	input  logic [hsfs_pkg::COL_W-1:0]   column_index,
	input  logic [hsfs_pkg::PROB_W-1:0]  prob_value,
	input  logic [hsfs_pkg::SYM_W-1:0]   symbol,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [hsfs_pkg::IDX_W-1:0]   state_number,
	output logic [hsfs_pkg::PROB_W-1:0]  alpha_value,
	output logic [hsfs_pkg::SCALE_W-1:0] scale_factor,
	output logic                         degenerate,
	output logic                         last
);

	localparam int NS = (MAX_STATES < hsfs_pkg::RESULT_LIMIT) ? MAX_STATES
		: hsfs_pkg::RESULT_LIMIT;
	localparam int SIW  = $clog2(NS);
	localparam int IA_W = $clog2(MAX_STATES);
	localparam int TA_W = $clog2(MAX_STATES * MAX_STATES);
	localparam int EA_W = $clog2(MAX_STATES * NUM_SYMBOLS);
	localparam int PW   = hsfs_pkg::PROB_W;
	localparam int F    = hsfs_pkg::PROB_FRAC_BITS;
	localparam int AW   = hsfs_pkg::ACC_W;
	localparam int TW   = hsfs_pkg::TOT_W;
	localparam int UW   = hsfs_pkg::U_W;
	localparam int QW   = hsfs_pkg::SCALE_W;

	logic [PW-1:0]   p_sat, init_rdata, trans_rdata, emis_rdata, e_val, alpha_val;
	logic            row_ok, col_t_ok, col_e_ok;
	logic            init_we, trans_we, emis_we;
	logic [IA_W-1:0] init_waddr, init_raddr;
	logic [TA_W-1:0] trans_waddr, trans_raddr;
	logic [EA_W-1:0] emis_waddr, emis_raddr;

	logic [hsfs_pkg::SYM_W-1:0] sym_q;
	logic                       sym_ok_q;
	logic                       mac_s1;
	logic [SIW-1:0]             i_s1;
	logic [AW-1:0]              acc_q;
	logic [AW:0]                acc_rnd;
	logic [2*PW-1:0]            mac_prod;
	logic [hsfs_pkg::FACT_W-1:0] fact_q;
	logic [UW-1:0]              u_prod, prod_q, u_cur;
	logic [UW-1:0]              u_q [NS];
	logic [PW-1:0]              alpha_q [NS];
	logic [TW-1:0]              total_q, rem_q, u_ext;
	logic [TW:0]                rem_sh;
	logic                       ld_ge, step_ge;
	logic [QW-1:0]              quo_q, scale_q;
	logic                       degen_q;
	logic                       out_valid_q, last_q, degenerate_q;
	logic [hsfs_pkg::IDX_W-1:0] state_number_q;
	logic [PW-1:0]              alpha_value_q;
	logic [QW-1:0]              scale_factor_q;

	assign p_sat    = (prob_value > hsfs_pkg::PROB_ONE) ? hsfs_pkg::PROB_ONE : prob_value;
	assign row_ok   = int'(row_index) < MAX_STATES;
	assign col_t_ok = int'(column_index) < MAX_STATES;
	assign col_e_ok = int'(column_index) < NUM_SYMBOLS;

	assign init_we  = cmd.tbl_write && (mode == hsfs_pkg::MODE_INIT) && row_ok;
	assign trans_we = cmd.tbl_write && (mode == hsfs_pkg::MODE_TRANS) && row_ok && col_t_ok;
	assign emis_we  = cmd.tbl_write && (mode == hsfs_pkg::MODE_EMIS) && row_ok && col_e_ok;

	assign init_waddr  = IA_W'(row_index);
	assign trans_waddr = TA_W'(row_index) * TA_W'(MAX_STATES) + TA_W'(column_index);
	assign emis_waddr  = EA_W'(row_index) * EA_W'(NUM_SYMBOLS) + EA_W'(column_index);
	assign init_raddr  = IA_W'(cmd.j);
	assign trans_raddr = TA_W'(cmd.i) * TA_W'(MAX_STATES) + TA_W'(cmd.j);
	assign emis_raddr  = EA_W'(cmd.j) * EA_W'(NUM_SYMBOLS) + EA_W'(sym_q);

	hsfs_ram #(.WIDTH(PW), .DEPTH(MAX_STATES)) u_init_ram (
		.clk(clk), .we(init_we), .waddr(init_waddr), .wdata(p_sat),
		.re(cmd.fetch), .raddr(init_raddr), .rdata(init_rdata)
	);

	hsfs_ram #(.WIDTH(PW), .DEPTH(MAX_STATES * MAX_STATES)) u_trans_ram (
		.clk(clk), .we(trans_we), .waddr(trans_waddr), .wdata(p_sat),
		.re(cmd.mac_issue), .raddr(trans_raddr), .rdata(trans_rdata)
	);

	hsfs_ram #(.WIDTH(PW), .DEPTH(MAX_STATES * NUM_SYMBOLS)) u_emis_ram (
		.clk(clk), .we(emis_we), .waddr(emis_waddr), .wdata(p_sat),
		.re(cmd.fetch), .raddr(emis_raddr), .rdata(emis_rdata)
	);

	assign mac_prod  = trans_rdata * alpha_q[i_s1];
	assign acc_rnd   = {1'b0, acc_q} + hsfs_pkg::ACC_HALF;
	assign e_val     = sym_ok_q ? emis_rdata : '0;
	assign u_prod    = fact_q * e_val;
	assign u_cur     = u_q[cmd.j[SIW-1:0]];
	assign u_ext     = TW'(u_cur);
	assign ld_ge     = (u_ext >= total_q);
	assign rem_sh    = {rem_q, 1'b0};
	assign step_ge   = (rem_sh >= {1'b0, total_q});
	assign alpha_val = degen_q ? '0 : quo_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NS; k++)
				alpha_q[k] <= '0;
		end else begin
			mac_s1 <= cmd.mac_issue;
			if (cmd.emit) begin
				alpha_q[cmd.j[SIW-1:0]] <= alpha_val;
				out_valid_q             <= 1'b1;
			end else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= cmd.i[SIW-1:0];
		if (cmd.begin_item) begin
			sym_q    <= symbol;
			sym_ok_q <= int'(symbol) < NUM_SYMBOLS;
			total_q  <= '0;
		end
		if (cmd.begin_item || cmd.uacc)
			acc_q <= '0;
		else if (mac_s1)
			acc_q <= acc_q + AW'(mac_prod);
		if (cmd.fact)
			fact_q <= cmd.start ? hsfs_pkg::FACT_W'(init_rdata) : acc_rnd[AW:F];
		if (cmd.umul)
			prod_q <= u_prod;
		if (cmd.uacc) begin
			u_q[cmd.j[SIW-1:0]] <= prod_q;
			total_q             <= total_q + TW'(prod_q);
		end
		if (cmd.ds_load) begin
			rem_q <= TW'(1);
			quo_q <= '0;
		end else if (cmd.da_load) begin
			rem_q <= ld_ge ? (u_ext - total_q) : u_ext;
			quo_q <= QW'(ld_ge);
		end else if (cmd.div_step) begin
			rem_q <= step_ge ? TW'(rem_sh - {1'b0, total_q}) : rem_sh[TW-1:0];
			quo_q <= {quo_q[QW-2:0], step_ge};
		end
		if (cmd.scale_save) begin
			degen_q <= (total_q == '0);
			scale_q <= (total_q <= hsfs_pkg::SMALL_LIM) ? '1 : quo_q;
		end
		if (cmd.emit) begin
			state_number_q <= cmd.j;
			alpha_value_q  <= alpha_val;
			scale_factor_q <= scale_q;
			degenerate_q   <= degen_q;
			last_q         <= cmd.last;
		end
	end

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign state_number  = state_number_q;
	assign alpha_value   = alpha_value_q;
	assign scale_factor  = scale_factor_q;
	assign degenerate    = degenerate_q;
	assign last          = last_q;

endmodule

### design/hmm_scaled_forward_step.sv
// Top level of the scaled HMM forward step.
// Load requests (mode 0..2) write the initial, transition or emission table.
// An observe request with n active states returns n results, one per state,
// with the normalized alpha in Q1.16 and the Q16.16 scale of the step. It occupies
// the block until its last result is emitted, and longer while the output is stalled.
// The transition sum runs through a single multiply-accumulate fed by the
// transition RAM (skipped on a sequence start); the rest is one radix-2 divider
// shared between the 48-step reciprocal and the 16-step division per state.
// Tables need no clearing pass; an entry read before it was written gives an
// arbitrary result.
module hmm_scaled_forward_step #(
	parameter int MAX_STATES  = hsfs_pkg::MAX_STATES_DEF,
	parameter int NUM_SYMBOLS = hsfs_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsfs_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [hsfs_pkg::IDX_W-1:0]   row_index,
	input  logic [hsfs_pkg::COL_W-1:0]   column_index,
	input  logic [hsfs_pkg::PROB_W-1:0]  prob_value,
	input  logic [hsfs_pkg::SYM_W-1:0]   symbol,
	input  logic                         seq_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hsfs_pkg::IDX_W-1:0]   state_number,
	output logic [hsfs_pkg::PROB_W-1:0]  alpha_value,
	output logic [hsfs_pkg::SCALE_W-1:0] scale_factor,
	output logic                         degenerate,
	output logic                         last
);

	hsfs_pkg::cmd_t cmd;
	hsfs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	hsfs_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .seq_start(seq_start), .cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data), .cmd(cmd), .sts(sts)
	);

	hsfs_dpath #(.MAX_STATES(MAX_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .mode(mode),
		.row_index(row_index), .column_index(column_index), .prob_value(prob_value),
		.symbol(symbol), .out_stall(out_stall), .out_valid(out_valid),
		.state_number(state_number), .alpha_value(alpha_value),
		.scale_factor(scale_factor), .degenerate(degenerate), .last(last)
	);

endmodule
